/* rtl/core/qsfm_pkg.sv */
// Package for the quasi-static frequency model: widths, command and status
// codes, controller states and the command/status words between controller
// and datapath. No dependencies.
package qsfm_pkg;

	localparam int MAX_SYMBOLS    = 256;
	localparam int MAX_LOG2_TOTAL = 16;
	localparam int SYM_W   = 8;
	localparam int NSYM_W  = 9;
	localparam int CNT_W   = MAX_LOG2_TOTAL + 1;
	localparam int IV_W    = 16;
	localparam int LOG_W   = 5;
	localparam int SUM_W   = CNT_W + SYM_W;
	localparam int CMD_W   = 3;
	localparam int ST_W    = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_CNT_W  = 5;

	localparam logic [CMD_W-1:0] CMD_UNIFORM = 3'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_APPLY   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DECODE  = 3'd5;

	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
	localparam logic [ST_W-1:0] ST_SUM   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SYMBOL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG2_TOTAL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 2'd2;

	typedef enum logic [2:0] {
		RA_IDX, RA_SYM, RA_MID, RA_LO, RA_LO1
	} rd_sel_t;

	typedef enum logic [2:0] {
		PW_NONE, PW_LOAD, PW_FILL, PW_HALF, PW_UPD
	} pw_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_UDIV, S_UFILL, S_AS_RD, S_AS_ACC, S_AS_CHK,
		S_RS_INIT, S_RS_RD, S_RS_WR, S_RS_IV, S_RS_DGO, S_RS_DIV,
		S_UP_RD, S_UP_WR, S_DEC_CHK, S_DEC_CMP, S_F_RD0, S_F_RD1,
		S_F_FIN, S_DONE
	} state_t;

	typedef struct packed {
		logic            capture;
		logic            div_start;
		logic            div_uni;
		logic            ld_uni;
		logic            ld_rs;
		logic            idx_zero;
		logic            idx_inc;
		logic            idx_last;
		logic            idx_dec;
		logic            sum_acc;
		logic            iv_two;
		logic            iv_grow;
		logic            rs_init;
		logic            rs_step;
		rd_sel_t         rd_sel;
		pw_t             pw;
		logic            upd_cnt;
		logic            dec_init;
		logic            dec_step;
		logic            q_init;
		logic            f_lat;
		logic            f_fin;
		logic            st_set;
		logic [ST_W-1:0] st_code;
		logic            load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             oor;
		logic             both_zero;
		logic             idx_end;
		logic             idx_zero;
		logic             sum_ok;
		logic             search_more;
		logic             div_done;
	} dp_stat_t;

endpackage

/* rtl/core/qsfm_div.sv */
// Restoring divider, one quotient bit per cycle, shared by uniform reset
// and rescale. Depends on qsfm_pkg.
module qsfm_div import qsfm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] dividend,
	input  logic [IV_W-1:0]  divisor,
	output logic [CNT_W-1:0] quotient,
	output logic [IV_W-1:0]  remainder,
	output logic             done
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0]     quo_q;
	logic [IV_W-1:0]      rem_q;
	logic [IV_W-1:0]      dvs_q;
	logic [IV_W:0]        trial;
	logic [IV_W:0]        diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[CNT_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(CNT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[IV_W-1:0] : trial[IV_W-1:0];
			quo_q <= {quo_q[CNT_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

/* rtl/core/qsfm_dp.sv */
// Datapath: configuration registers, count and cumulative memories, working
// registers, divider and result registers. Depends on qsfm_pkg, qsfm_div.
module qsfm_dp import qsfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [CMD_W-1:0]      command,
	input  logic [SYM_W-1:0]      symbol,
	input  logic [CNT_W-1:0]      value,
	input  ctrl_cmd_t             ctl,
	output dp_stat_t              stat,
	output logic [SYM_W-1:0]      found_symbol,
	output logic [CNT_W-1:0]      frequency,
	output logic [CNT_W-1:0]      cum_start,
	output logic [ST_W-1:0]       status
);

	logic [NSYM_W-1:0] sc_q;
	logic [LOG_W-1:0]  log_q;
	logic [IV_W-1:0]   tgt_q;

	logic [CNT_W-1:0] pend_mem [MAX_SYMBOLS];
	logic [CNT_W-1:0] cum_mem  [MAX_SYMBOLS];
	logic [CNT_W-1:0] pend_rd_q;
	logic [CNT_W-1:0] cum_rd_q;

	logic [CMD_W-1:0]  cmd_q;
	logic [SYM_W-1:0]  sym_q;
	logic [CNT_W-1:0]  val_q;
	logic [NSYM_W-1:0] idx_q;
	logic [NSYM_W-1:0] lo_q;
	logic [NSYM_W-1:0] hi_q;
	logic [CNT_W-1:0]  acc_q;
	logic [CNT_W-1:0]  miss_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  base_q;
	logic [NSYM_W-1:0] rem_q;
	logic [IV_W-1:0]   iv_q;
	logic [CNT_W-1:0]  incr_q;
	logic [IV_W-1:0]   plus_q;
	logic [IV_W-1:0]   plain_q;
	logic [CNT_W-1:0]  freq_q;
	logic [CNT_W-1:0]  cst_q;
	logic [ST_W-1:0]   st_q;

	logic [SYM_W-1:0]  found_q;
	logic [CNT_W-1:0]  ofreq_q;
	logic [CNT_W-1:0]  ocst_q;
	logic [ST_W-1:0]   ost_q;

	logic [NSYM_W-1:0] n_w;
	logic [LOG_W-1:0]  l_w;
	logic [CNT_W-1:0]  tot_w;
	logic [NSYM_W-1:0] mid_w;
	logic [NSYM_W-1:0] lo1_w;
	logic [NSYM_W:0]   lohi_w;
	logic [SYM_W-1:0]  rd_addr;
	logic              pend_we;
	logic [SYM_W-1:0]  pend_wa;
	logic [CNT_W-1:0]  pend_wd;
	logic [CNT_W-1:0]  half_w;
	logic [IV_W:0]     dbl_w;
	logic [IV_W-1:0]   grow_w;
	logic [CNT_W-1:0]  div_dvd;
	logic [IV_W-1:0]   div_dvs;
	logic [CNT_W-1:0]  div_quo;
	logic [IV_W-1:0]   div_rem;
	logic              div_done;

	always_comb begin
		if (sc_q < NSYM_W'(2))
			n_w = NSYM_W'(2);
		else if (sc_q > NSYM_W'(MAX_SYMBOLS))
			n_w = NSYM_W'(MAX_SYMBOLS);
		else
			n_w = sc_q;
		l_w   = (log_q > LOG_W'(MAX_LOG2_TOTAL)) ? LOG_W'(MAX_LOG2_TOTAL) : log_q;
		tot_w = CNT_W'(1) << l_w;
	end

	assign lohi_w = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_w  = lohi_w[NSYM_W:1];
	assign lo1_w  = lo_q + 1'b1;
	assign half_w = (pend_rd_q[CNT_W-1:1] == '0) ? CNT_W'(1) : {1'b0, pend_rd_q[CNT_W-1:1]};

	always_comb begin
		dbl_w  = {iv_q, 1'b0};
		grow_w = iv_q;
		if (iv_q < tgt_q)
			grow_w = (dbl_w > {1'b0, tgt_q}) ? tgt_q : dbl_w[IV_W-1:0];
		if (grow_w == '0)
			grow_w = IV_W'(2);
	end

	always_comb begin
		unique case (ctl.rd_sel)
			RA_IDX:  rd_addr = idx_q[SYM_W-1:0];
			RA_SYM:  rd_addr = sym_q;
			RA_MID:  rd_addr = mid_w[SYM_W-1:0];
			RA_LO:   rd_addr = lo_q[SYM_W-1:0];
			RA_LO1:  rd_addr = lo1_w[SYM_W-1:0];
			default: rd_addr = idx_q[SYM_W-1:0];
		endcase
	end

	always_comb begin
		pend_we = 1'b1;
		pend_wa = idx_q[SYM_W-1:0];
		pend_wd = half_w;
		unique case (ctl.pw)
			PW_NONE: pend_we = 1'b0;
			PW_LOAD: begin
				pend_wa = sym_q;
				pend_wd = val_q;
			end
			PW_FILL: pend_wd = base_q + CNT_W'(idx_q < rem_q);
			PW_HALF: pend_wd = half_w;
			PW_UPD: begin
				pend_wa = sym_q;
				pend_wd = pend_rd_q + incr_q + CNT_W'(plus_q != '0);
			end
			default: pend_we = 1'b0;
		endcase
	end

	// Rescale reads the count memory and writes the cumulative memory.
	always_ff @(posedge clk) begin
		if (pend_we)
			pend_mem[pend_wa] <= pend_wd;
		if (ctl.rs_step)
			cum_mem[idx_q[SYM_W-1:0]] <= acc_q - pend_rd_q;
		pend_rd_q <= pend_mem[rd_addr];
		cum_rd_q  <= cum_mem[rd_addr];
	end

	assign div_dvd = ctl.div_uni ? tot_w : miss_q;
	assign div_dvs = ctl.div_uni ? IV_W'(n_w) : iv_q;

	qsfm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (div_dvd),
		.divisor   (div_dvs),
		.quotient  (div_quo),
		.remainder (div_rem),
		.done      (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q    <= NSYM_W'(256);
			log_q   <= LOG_W'(16);
			tgt_q   <= IV_W'(1024);
			iv_q    <= IV_W'(2);
			incr_q  <= '0;
			plus_q  <= '0;
			plain_q <= '0;
			cmd_q   <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_SYMBOL_COUNT: sc_q  <= cfg_data[NSYM_W-1:0];
					REG_LOG2_TOTAL:   log_q <= cfg_data[LOG_W-1:0];
					REG_TARGET:       tgt_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctl.capture)
				cmd_q <= command;
			if (ctl.iv_two)
				iv_q <= IV_W'(2);
			else if (ctl.iv_grow)
				iv_q <= grow_w;
			if (ctl.ld_rs) begin
				incr_q  <= div_quo;
				plus_q  <= div_rem;
				plain_q <= iv_q - div_rem;
			end else if (ctl.upd_cnt) begin
				if (plus_q != '0)
					plus_q <= plus_q - 1'b1;
				else if (plain_q != '0)
					plain_q <= plain_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			sym_q  <= symbol;
			val_q  <= value;
			freq_q <= '0;
			cst_q  <= '0;
			st_q   <= ST_OK;
		end
		if (ctl.st_set)
			st_q <= ctl.st_code;
		if (ctl.ld_uni) begin
			base_q <= div_quo;
			rem_q  <= div_rem[NSYM_W-1:0];
		end
		if (ctl.idx_zero)
			idx_q <= '0;
		else if (ctl.idx_last)
			idx_q <= n_w - 1'b1;
		else if (ctl.idx_inc)
			idx_q <= idx_q + 1'b1;
		else if (ctl.idx_dec)
			idx_q <= idx_q - 1'b1;
		if (ctl.idx_zero)
			sum_q <= '0;
		else if (ctl.sum_acc)
			sum_q <= sum_q + SUM_W'(pend_rd_q);
		if (ctl.rs_init) begin
			acc_q  <= tot_w;
			miss_q <= tot_w;
		end else if (ctl.rs_step) begin
			acc_q  <= acc_q - pend_rd_q;
			miss_q <= miss_q - half_w;
		end else if (ctl.f_lat)
			acc_q <= cum_rd_q;
		if (ctl.dec_init) begin
			lo_q <= '0;
			hi_q <= n_w;
		end else if (ctl.q_init)
			lo_q <= NSYM_W'(sym_q);
		else if (ctl.dec_step) begin
			if (val_q < cum_rd_q)
				hi_q <= mid_w;
			else
				lo_q <= mid_w;
		end
		if (ctl.f_lat)
			cst_q <= cum_rd_q;
		if (ctl.f_fin)
			freq_q <= ((lo1_w >= n_w) ? tot_w : cum_rd_q) - acc_q;
		if (ctl.load_out) begin
			found_q <= (cmd_q == CMD_DECODE) ? lo_q[SYM_W-1:0] : sym_q;
			ofreq_q <= freq_q;
			ocst_q  <= cst_q;
			ost_q   <= st_q;
		end
	end

	assign stat.cmd         = cmd_q;
	assign stat.oor         = {1'b0, sym_q} >= n_w;
	assign stat.both_zero   = (plus_q == '0) && (plain_q == '0);
	assign stat.idx_end     = idx_q == (n_w - 1'b1);
	assign stat.idx_zero    = idx_q == '0;
	assign stat.sum_ok      = sum_q == SUM_W'(tot_w);
	assign stat.search_more = (hi_q - lo_q) > NSYM_W'(1);
	assign stat.div_done    = div_done;

	assign found_symbol = found_q;
	assign frequency    = ofreq_q;
	assign cum_start    = ocst_q;
	assign status       = ost_q;

endmodule

/* rtl/core/qsfm_ctrl.sv */
// Controller: sequences each command word through the datapath and holds
// the output valid flag. Depends on qsfm_pkg.
module qsfm_ctrl import qsfm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t ctl
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DISP;
			S_DISP: begin
				unique case (stat.cmd)
					CMD_UNIFORM: state_d = S_UDIV;
					CMD_LOAD:    state_d = S_DONE;
					CMD_APPLY:   state_d = S_AS_RD;
					CMD_UPDATE: begin
						if (stat.oor)
							state_d = S_DONE;
						else if (stat.both_zero)
							state_d = S_RS_INIT;
						else
							state_d = S_UP_RD;
					end
					CMD_QUERY:  state_d = stat.oor ? S_DONE : S_F_RD0;
					CMD_DECODE: state_d = S_DEC_CHK;
					default:    state_d = S_DONE;
				endcase
			end
			S_UDIV:    if (stat.div_done) state_d = S_UFILL;
			S_UFILL:   if (stat.idx_end) state_d = S_RS_INIT;
			S_AS_RD:   state_d = S_AS_ACC;
			S_AS_ACC:  state_d = stat.idx_end ? S_AS_CHK : S_AS_RD;
			S_AS_CHK:  state_d = stat.sum_ok ? S_RS_INIT : S_DONE;
			S_RS_INIT: state_d = S_RS_RD;
			S_RS_RD:   state_d = S_RS_WR;
			S_RS_WR:   state_d = stat.idx_zero ? S_RS_IV : S_RS_RD;
			S_RS_IV:   state_d = S_RS_DGO;
			S_RS_DGO:  state_d = S_RS_DIV;
			S_RS_DIV: begin
				if (stat.div_done)
					state_d = (stat.cmd == CMD_UPDATE) ? S_UP_RD : S_DONE;
			end
			S_UP_RD:   state_d = S_UP_WR;
			S_UP_WR:   state_d = S_DONE;
			S_DEC_CHK: state_d = stat.search_more ? S_DEC_CMP : S_F_RD0;
			S_DEC_CMP: state_d = S_DEC_CHK;
			S_F_RD0:   state_d = S_F_RD1;
			S_F_RD1:   state_d = S_F_FIN;
			S_F_FIN:   state_d = S_DONE;
			S_DONE:    if (out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl        = '0;
		ctl.rd_sel = RA_IDX;
		ctl.pw     = PW_NONE;
		unique case (state_q)
			S_IDLE: ctl.capture = in_valid;
			S_DISP: begin
				unique case (stat.cmd)
					CMD_UNIFORM: begin
						ctl.div_start = 1'b1;
						ctl.div_uni   = 1'b1;
					end
					CMD_LOAD: begin
						if (stat.oor) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_RANGE;
						end else
							ctl.pw = PW_LOAD;
					end
					CMD_APPLY: ctl.idx_zero = 1'b1;
					CMD_UPDATE, CMD_QUERY: begin
						if (stat.oor) begin
							ctl.st_set  = 1'b1;
							ctl.st_code = ST_RANGE;
						end else
							ctl.q_init = 1'b1;
					end
					CMD_DECODE: ctl.dec_init = 1'b1;
					default: ;
				endcase
			end
			S_UDIV: begin
				ctl.ld_uni   = stat.div_done;
				ctl.idx_zero = stat.div_done;
			end
			S_UFILL: begin
				ctl.pw      = PW_FILL;
				ctl.idx_inc = 1'b1;
				ctl.iv_two  = stat.idx_end;
			end
			S_AS_RD: ctl.rd_sel = RA_IDX;
			S_AS_ACC: begin
				ctl.sum_acc = 1'b1;
				ctl.idx_inc = 1'b1;
			end
			S_AS_CHK: begin
				if (stat.sum_ok)
					ctl.iv_two = 1'b1;
				else begin
					ctl.st_set  = 1'b1;
					ctl.st_code = ST_SUM;
				end
			end
			S_RS_INIT: begin
				ctl.rs_init  = 1'b1;
				ctl.idx_last = 1'b1;
			end
			S_RS_RD: ctl.rd_sel = RA_IDX;
			S_RS_WR: begin
				ctl.rs_step = 1'b1;
				ctl.pw      = PW_HALF;
				ctl.idx_dec = !stat.idx_zero;
			end
			S_RS_IV:  ctl.iv_grow = 1'b1;
			S_RS_DGO: ctl.div_start = 1'b1;
			S_RS_DIV: ctl.ld_rs = stat.div_done;
			S_UP_RD:  ctl.rd_sel = RA_SYM;
			S_UP_WR: begin
				ctl.pw      = PW_UPD;
				ctl.upd_cnt = 1'b1;
			end
			S_DEC_CHK: ctl.rd_sel = RA_MID;
			S_DEC_CMP: begin
				ctl.rd_sel   = RA_MID;
				ctl.dec_step = 1'b1;
			end
			S_F_RD0: ctl.rd_sel = RA_LO;
			S_F_RD1: begin
				ctl.rd_sel = RA_LO1;
				ctl.f_lat  = 1'b1;
			end
			S_F_FIN: ctl.f_fin = 1'b1;
			S_DONE:  ctl.load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

endmodule

/* rtl/core/quasi_static_frequency_model.sv */
// Quasi-static frequency model top level. Decode runs a binary search through the single
// cumulative read port. A rescale reads and halves each symbol's count, then runs a
// divide; uniform reset divides and fills before it, apply sums the table first. One
// word in flight; the output register holds a result while the next word is taken.
// Reset: interval two, counters zero, configuration at defaults; the memories are not
// cleared.
module quasi_static_frequency_model import qsfm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      command,
	input  logic [SYM_W-1:0]      symbol,
	input  logic [CNT_W-1:0]      value,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SYM_W-1:0]      found_symbol,
	output logic [CNT_W-1:0]      frequency,
	output logic [CNT_W-1:0]      cum_start,
	output logic [ST_W-1:0]       status
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	qsfm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	qsfm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.command      (command),
		.symbol       (symbol),
		.value        (value),
		.ctl          (ctl),
		.stat         (stat),
		.found_symbol (found_symbol),
		.frequency    (frequency),
		.cum_start    (cum_start),
		.status       (status)
	);

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the quasi-static frequency model: drives command words
// and register writes, predicts each result with a scoreboard class and compares them.
// Depends on qsfm_pkg and quasi_static_frequency_model.
module testbench;
	import qsfm_pkg::*;

	typedef struct packed {
		logic [SYM_W-1:0] sym;
		logic [CNT_W-1:0] freq;
		logic [CNT_W-1:0] cstart;
		logic [ST_W-1:0]  st;
	} freq_result_t;

	localparam int unsigned CNT_MASK = (1 << CNT_W) - 1;
	localparam int unsigned LIMIT    = 4000000;
	localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

	class freq_scoreboard;
		int unsigned nsym_reg, log_reg, target_reg;
		int unsigned counts[MAX_SYMBOLS];
		int unsigned cums[MAX_SYMBOLS];
		int unsigned interval, step_inc, plus_left, plain_left;
		freq_result_t expected_q[$];
		int errors;

		function new();
			nsym_reg = 256;
			log_reg = 16;
			target_reg = 1024;
			interval = 2;
			step_inc = 0;
			plus_left = 0;
			plain_left = 0;
			errors = 0;
			foreach (counts[i]) begin
				counts[i] = 0;
				cums[i] = 0;
			end
		endfunction

		function int unsigned alphabet();
			if (nsym_reg < 2) return 2;
			if (nsym_reg > MAX_SYMBOLS) return MAX_SYMBOLS;
			return nsym_reg;
		endfunction

		function int unsigned mass();
			return 1 << ((log_reg > MAX_LOG2_TOTAL) ? MAX_LOG2_TOTAL : log_reg);
		endfunction

		function int unsigned cum_of(int unsigned i);
			if (i >= alphabet()) return mass();
			return cums[i];
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SYMBOL_COUNT: nsym_reg = data[NSYM_W-1:0];
				REG_LOG2_TOTAL:   log_reg = data[LOG_W-1:0];
				REG_TARGET:       target_reg = data;
				default: ;
			endcase
		endfunction

		function void publish();
			int unsigned n, missing, c, iv;
			n = alphabet();
			missing = mass();
			c = mass();
			for (int i = n - 1; i >= 0; i--) begin
				c = (c - counts[i]) & CNT_MASK;
				cums[i] = c;
				counts[i] = counts[i] >> 1;
				if (counts[i] < 1) counts[i] = 1;
				missing = (missing - counts[i]) & CNT_MASK;
			end
			if (interval < target_reg) begin
				iv = interval << 1;
				if (iv > target_reg) iv = target_reg;
				interval = iv;
			end
			if (interval == 0) interval = 2;
			step_inc = (missing / interval) & CNT_MASK;
			plus_left = missing % interval;
			plain_left = interval - plus_left;
		endfunction

		function void note(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym, logic [CNT_W-1:0] val);
			int unsigned n, tot, lo, hi, mid;
			longint unsigned sum;
			freq_result_t r;
			n = alphabet();
			tot = mass();
			r = '0;
			r.sym = sym;
			r.st = ST_OK;
			case (cmd)
				CMD_UNIFORM: begin
					for (int i = 0; i < n; i++)
						counts[i] = (tot / n + ((i < tot % n) ? 1 : 0)) & CNT_MASK;
					interval = 2;
					publish();
				end
				CMD_LOAD: begin
					if (sym >= n) r.st = ST_RANGE;
					else counts[sym] = val;
				end
				CMD_APPLY: begin
					sum = 0;
					for (int i = 0; i < n; i++) sum += counts[i];
					if (sum != tot) r.st = ST_SUM;
					else begin
						interval = 2;
						publish();
					end
				end
				CMD_UPDATE: begin
					if (sym >= n) r.st = ST_RANGE;
					else begin
						if (plus_left == 0 && plain_left == 0) publish();
						if (plus_left > 0) begin
							plus_left--;
							counts[sym] = (counts[sym] + step_inc + 1) & CNT_MASK;
						end else begin
							if (plain_left > 0) plain_left--;
							counts[sym] = (counts[sym] + step_inc) & CNT_MASK;
						end
					end
				end
				CMD_QUERY: begin
					if (sym >= n) r.st = ST_RANGE;
					else begin
						r.cstart = CNT_W'(cum_of(sym));
						r.freq = CNT_W'((cum_of(sym + 1) - cum_of(sym)) & CNT_MASK);
					end
				end
				CMD_DECODE: begin
					lo = 0;
					hi = n;
					while (hi - lo > 1) begin
						mid = (lo + hi) >> 1;
						if (val < cum_of(mid)) hi = mid;
						else lo = mid;
					end
					r.sym = SYM_W'(lo);
					r.cstart = CNT_W'(cum_of(lo));
					r.freq = CNT_W'((cum_of(lo + 1) - cum_of(lo)) & CNT_MASK);
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check(freq_result_t got);
			freq_result_t exp_r;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result sym=%0d freq=%0d cum=%0d status=%0d",
					$time, got.sym, got.freq, got.cstart, got.st);
				errors++;
				return;
			end
			exp_r = expected_q.pop_front();
			if (got.sym !== exp_r.sym) begin
				$display("%0t: found_symbol expected %0d actual %0d", $time, exp_r.sym, got.sym);
				errors++;
			end
			if (got.freq !== exp_r.freq) begin
				$display("%0t: frequency expected %0d actual %0d", $time, exp_r.freq, got.freq);
				errors++;
			end
			if (got.cstart !== exp_r.cstart) begin
				$display("%0t: cum_start expected %0d actual %0d", $time, exp_r.cstart,
					got.cstart);
				errors++;
			end
			if (got.st !== exp_r.st) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_r.st, got.st);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [CMD_W-1:0]      command;
	logic [SYM_W-1:0]      symbol;
	logic [CNT_W-1:0]      value;
	logic                  out_valid;
	logic                  out_ready;
	logic [SYM_W-1:0]      found_symbol;
	logic [CNT_W-1:0]      frequency;
	logic [CNT_W-1:0]      cum_start;
	logic [ST_W-1:0]       status;

	freq_scoreboard sb = new();
	int unsigned cycles = 0;
	int burst_left = 0;

	quasi_static_frequency_model u_top (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check({found_symbol, frequency, cum_start, status});

	// receiver: random stalls, a quiet stretch, and one long hold-off
	initial begin
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (cycles > 3000 && cycles <= 3400) out_ready <= 0;
			else if ((cycles / 2000) % 3 == 2) out_ready <= 1;
			else out_ready <= ($urandom_range(0, 99) < 65);
		end
	end

	task automatic send_word(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym,
			logic [CNT_W-1:0] val);
		in_valid <= 1;
		command <= cmd;
		symbol <= sym;
		value <= val;
		do @(posedge clk); while (!(in_valid && in_ready));
		sb.note(cmd, sym, val);
		if (burst_left > 0) burst_left--;
		else begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic write_regs(int unsigned nsym, int unsigned lg, int unsigned tgt);
		logic [CFG_DATA_W-1:0] data [3];
		data[0] = CFG_DATA_W'(nsym);
		data[1] = CFG_DATA_W'(lg);
		data[2] = CFG_DATA_W'(tgt);
		in_valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= data[i];
			do @(posedge clk); while (!(cfg_valid && cfg_ready));
			sb.write_reg(CFG_IDX_W'(i), data[i]);
		end
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol();
		if ($urandom_range(0, 99) < 88) return SYM_W'($urandom_range(0, sb.alphabet() - 1));
		return SYM_W'($urandom_range(0, 255));
	endfunction

	// load a full table summing to the total, sometimes off by one, then apply
	task automatic load_and_apply(bit broken);
		int unsigned n, tot, sum, c;
		n = sb.alphabet();
		tot = sb.mass();
		sum = 0;
		for (int i = 0; i < n - 1; i++) begin
			c = $urandom_range(0, 2 * tot / n);
			if (c > tot - sum) c = tot - sum;
			sum += c;
			send_word(CMD_LOAD, SYM_W'(i), CNT_W'(c));
		end
		send_word(CMD_LOAD, SYM_W'(n - 1), CNT_W'(tot - sum + (broken ? 1 : 0)));
		send_word(CMD_APPLY, SYM_W'($urandom), CNT_W'($urandom));
	endtask

	task automatic random_phase(int items);
		int k, r;
		int unsigned tot;
		tot = sb.mass();
		send_word(CMD_UNIFORM, SYM_W'($urandom), CNT_W'($urandom));
		k = 1;
		while (k < items) begin
			r = $urandom_range(0, 99);
			if (r < 45) send_word(CMD_UPDATE, pick_symbol(), CNT_W'($urandom));
			else if (r < 60) send_word(CMD_QUERY, pick_symbol(), CNT_W'($urandom));
			else if (r < 80) send_word(CMD_DECODE, SYM_W'($urandom),
				CNT_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 131071) :
				$urandom_range(0, tot - 1)));
			else if (r < 85 && sb.alphabet() <= 16) begin
				load_and_apply($urandom_range(0, 4) == 0);
				k += sb.alphabet();
			end else if (r < 90) send_word(CMD_LOAD, pick_symbol(), CNT_W'($urandom));
			else if (r < 93) send_word(CMD_APPLY, SYM_W'($urandom), CNT_W'($urandom));
			else if (r < 95) send_word(CMD_UNIFORM, SYM_W'($urandom), CNT_W'($urandom));
			else send_word($urandom_range(0, 1) ? CMD_SPARE6 : CMD_SPARE7,
				SYM_W'($urandom), CNT_W'($urandom));
			k++;
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 0;
		command = '0;
		symbol = '0;
		value = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// full alphabet first so every table entry is written
		send_word(CMD_UNIFORM, 0, 0);
		send_word(CMD_QUERY, 0, 0);
		send_word(CMD_QUERY, 255, 0);
		send_word(CMD_DECODE, 0, 0);
		send_word(CMD_DECODE, 0, 65535);
		send_word(CMD_DECODE, 0, 65536);
		send_word(CMD_DECODE, 0, 131071);
		send_word(CMD_UPDATE, 0, 0);
		send_word(CMD_UPDATE, 255, 0);
		send_word(CMD_UPDATE, 255, 0);
		send_word(CMD_SPARE6, 255, 131071);
		send_word(CMD_SPARE7, 0, 0);
		send_word(CMD_LOAD, 3, 131071);
		send_word(CMD_APPLY, 0, 0);

		write_regs(4, 8, 2);
		send_word(CMD_UNIFORM, 0, 0);
		send_word(CMD_LOAD, 9, 5);
		send_word(CMD_QUERY, 200, 0);
		send_word(CMD_UPDATE, 4, 0);
		load_and_apply(0);
		send_word(CMD_DECODE, 0, 255);

		write_regs(256, 16, 65535);
		random_phase(120);
		write_regs(2, 8, 2);
		random_phase(120);
		write_regs(0, 31, 0);
		random_phase(100);
		write_regs(16'hFFFF, 12, 3);
		random_phase(100);
		for (int p = 0; p < 6; p++) begin
			write_regs(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(2, 16),
				$urandom_range(8, 16), $urandom_range(2, 40));
			random_phase(100);
		end

		in_valid <= 0;
		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
